FILE: rtl/iedi_pkg.sv
// ----------------------------------------------------------------------------
// iedi_pkg - shared definitions for the edge density integral image
// Frame limits, field widths, Gaussian weights, the command item passed from
// the front part to the back part, and the frame size clamps.
// ----------------------------------------------------------------------------
`default_nettype none

package iedi_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int HD_W  = $clog2(MAX_HEIGHT + 1);

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int POS_OUT_W = 10;
  localparam int SUM_W     = 32;
  localparam int GRAD_W    = 11;  // |gx|+|gy| tops out at 2040
  localparam int MIN_DIM   = 5;

  localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // blur arithmetic: row sums, total, reciprocal of 159 (exact for totals < 2^16)
  localparam int ROW_SUM_W   = 14;
  localparam int BLUR_SUM_W  = 16;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP_159 = 17'd105518;

  localparam logic [3:0] GAUSS_W [5][5] = '{
    '{4'd2, 4'd4,  4'd5,  4'd4, 4'd2},
    '{4'd4, 4'd9,  4'd12, 4'd9, 4'd4},
    '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
    '{4'd4, 4'd9,  4'd12, 4'd9, 4'd4},
    '{4'd2, 4'd4,  4'd5,  4'd4, 4'd2}
  };

  // 3x3 blur neighbourhood, [row][col], row 0 on top
  typedef logic [2:0][2:0][PIX_W-1:0] win3_t;

  typedef struct packed {
    win3_t             gw;
    logic [COL_W-1:0]  pc;
    logic [ROW_W-1:0]  pr;
    logic              col_flush;
    logic              row_flush;
    logic [WD_W-1:0]   w;
    logic [HD_W-1:0]   h;
  } cmd_t;

  function automatic logic [WD_W-1:0] clamp_w(input logic [CFG_W-1:0] v);
    logic [WD_W-1:0] res;
    if (32'(v) < MIN_DIM) res = WD_W'(MIN_DIM);
    else if (32'(v) > MAX_WIDTH) res = WD_W'(MAX_WIDTH);
    else res = WD_W'(v);
    return res;
  endfunction

  function automatic logic [HD_W-1:0] clamp_h(input logic [CFG_W-1:0] v);
    logic [HD_W-1:0] res;
    if (32'(v) < MIN_DIM) res = HD_W'(MIN_DIM);
    else if (32'(v) > MAX_HEIGHT) res = HD_W'(MAX_HEIGHT);
    else res = HD_W'(v);
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/iedi_ram.sv
// ----------------------------------------------------------------------------
// iedi_ram - generic simple dual port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module iedi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/iedi_front.sv
// ----------------------------------------------------------------------------
// iedi_front - pixel intake, Gaussian blur and gradient window
// Five stage pipeline that never stalls; intake is held off while the
// command queue could not absorb every item still in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module iedi_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [iedi_pkg::PIX_W-1:0]      pixel,
  input  logic [iedi_pkg::CFG_W-1:0]      frame_width,
  input  logic [iedi_pkg::CFG_W-1:0]      frame_height,
  input  logic [iedi_pkg::QCNT_W-1:0]     q_count,
  output logic                            push,
  output iedi_pkg::cmd_t                  push_cmd
);

  localparam int PW  = iedi_pkg::PIX_W;
  localparam int CW  = iedi_pkg::COL_W;
  localparam int RW  = iedi_pkg::ROW_W;
  localparam int WW  = iedi_pkg::WD_W;
  localparam int HW  = iedi_pkg::HD_W;
  localparam int RSW = iedi_pkg::ROW_SUM_W;
  localparam int BSW = iedi_pkg::BLUR_SUM_W;
  localparam int PRW = BSW + iedi_pkg::RECIP_W;
  localparam int CNW = iedi_pkg::QCNT_W + 1;

  typedef struct packed {
    logic [CW-1:0] pc;
    logic [RW-1:0] pr;
    logic [WW-1:0] w;
    logic [HW-1:0] h;
    logic          col_end;
    logic          row_end;
  } pos_t;

  // intake position
  logic [CW-1:0] pixel_col;
  logic [RW-1:0] pixel_row;
  logic [WW-1:0] act_w, w_cur;
  logic [HW-1:0] act_h, h_cur;
  logic          accept, first_pix, col_end, row_end;

  // pipeline
  logic          s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  pos_t          s1_pos, s2_pos, s3_pos, s4_pos, s5_pos, in_pos;
  logic [PW-1:0] s1_pix;
  logic [RSW-1:0] s3_rows [5];
  logic [RSW-1:0] row_sum [5];
  logic [BSW-1:0] s4_total;
  logic [PRW-1:0] blur_prod;
  logic [PW-1:0]  s5_blur, blur_val;

  logic [PW-1:0]  bw [5][5];
  logic [PW-1:0]  new_col [5];
  iedi_pkg::win3_t gw, gw_next;

  logic [4*PW-1:0] pl_rdata, pl_wdata;
  logic [2*PW-1:0] bl_rdata, bl_wdata;
  logic [2:0]      inflight;
  logic            gw_shift;

  assign first_pix = (pixel_col == '0) && (pixel_row == '0);
  assign w_cur     = first_pix ? iedi_pkg::clamp_w(frame_width) : act_w;
  assign h_cur     = first_pix ? iedi_pkg::clamp_h(frame_height) : act_h;
  assign col_end   = (WW'(pixel_col) == w_cur - 1'b1);
  assign row_end   = (HW'(pixel_row) == h_cur - 1'b1);
  assign accept    = in_valid && !in_stall;

  assign in_pos = '{pc: pixel_col, pr: pixel_row, w: w_cur, h: h_cur,
                    col_end: col_end, row_end: row_end};

  // hold off intake unless every item in flight still finds a queue slot
  assign inflight = 3'(s1_valid) + 3'(s2_valid) + 3'(s3_valid) + 3'(s4_valid)
                  + 3'(s5_valid);
  assign in_stall = (CNW'(q_count) + CNW'(inflight)) >= CNW'(iedi_pkg::QUEUE_DEPTH);

  // four pixel lines, one byte lane per line, addressed by column
  iedi_ram #(.WIDTH(4*PW), .DEPTH(iedi_pkg::MAX_WIDTH)) u_pix_lines (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_pos.pc),
    .wdata (pl_wdata),
    .re    (accept),
    .raddr (pixel_col),
    .rdata (pl_rdata)
  );

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      pl_wdata[l*PW +: PW] = (2'(l) == s1_pos.pr[1:0]) ? s1_pix : pl_rdata[l*PW +: PW];
    end
    for (int i = 0; i < 4; i++) begin
      new_col[i] = pl_rdata[32'(2'(s1_pos.pr[1:0] + 2'(i))) * PW +: PW];
    end
    new_col[4] = s1_pix;
  end

  // weighted row sums of the 5x5 window
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      row_sum[i] = '0;
      for (int j = 0; j < 5; j++) begin
        row_sum[i] = row_sum[i] + RSW'(bw[i][j]) * RSW'(iedi_pkg::GAUSS_W[i][j]);
      end
    end
  end

  // divide by 159 through the reciprocal; zero within two pixels of the edge
  assign blur_prod = PRW'(s4_total) * PRW'(iedi_pkg::RECIP_159);
  assign blur_val  = (s4_pos.pc >= CW'(4) && s4_pos.pr >= RW'(4))
                   ? blur_prod[iedi_pkg::RECIP_SHIFT +: PW] : '0;

  // two blur lines, lane chosen by row parity
  iedi_ram #(.WIDTH(2*PW), .DEPTH(iedi_pkg::MAX_WIDTH)) u_blur_lines (
    .clk   (clk),
    .we    (gw_shift),
    .waddr (s5_pos.pc - CW'(2)),
    .wdata (bl_wdata),
    .re    (s4_valid && s4_pos.pc >= CW'(2)),
    .raddr (s4_pos.pc - CW'(2)),
    .rdata (bl_rdata)
  );

  assign gw_shift = s5_valid && (s5_pos.pc >= CW'(2));

  always_comb begin
    bl_wdata = bl_rdata;
    bl_wdata[32'(s5_pos.pr[0]) * PW +: PW] = s5_blur;
    gw_next = gw;
    if (gw_shift) begin
      for (int i = 0; i < 3; i++) begin
        gw_next[i][0] = gw[i][1];
        gw_next[i][1] = gw[i][2];
      end
      gw_next[0][2] = bl_rdata[32'(s5_pos.pr[0]) * PW +: PW];
      gw_next[1][2] = bl_rdata[32'(!s5_pos.pr[0]) * PW +: PW];
      gw_next[2][2] = s5_blur;
    end
  end

  assign push = s5_valid && (s5_pos.pc >= CW'(3)) && (s5_pos.pr >= RW'(3));
  assign push_cmd = '{gw: gw_next, pc: s5_pos.pc, pr: s5_pos.pr,
                      col_flush: s5_pos.col_end, row_flush: s5_pos.row_end,
                      w: s5_pos.w, h: s5_pos.h};

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_col <= '0;
      pixel_row <= '0;
      act_w     <= iedi_pkg::clamp_w(iedi_pkg::DIM_RESET);
      act_h     <= iedi_pkg::clamp_h(iedi_pkg::DIM_RESET);
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      bw        <= '{default: '0};
      gw        <= '0;
    end else begin
      if (accept) begin
        act_w <= w_cur;
        act_h <= h_cur;
        if (col_end) begin
          pixel_col <= '0;
          pixel_row <= row_end ? '0 : pixel_row + 1'b1;
        end else begin
          pixel_col <= pixel_col + 1'b1;
        end
      end
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      if (s1_valid) begin
        for (int i = 0; i < 5; i++) begin
          for (int j = 0; j < 4; j++) begin
            bw[i][j] <= bw[i][j+1];
          end
          bw[i][4] <= new_col[i];
        end
      end
      gw <= gw_next;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    s1_pix   <= pixel;
    s1_pos   <= in_pos;
    s2_pos   <= s1_pos;
    s3_pos   <= s2_pos;
    s4_pos   <= s3_pos;
    s5_pos   <= s4_pos;
    s3_rows  <= row_sum;
    s4_total <= BSW'(s3_rows[0]) + BSW'(s3_rows[1]) + BSW'(s3_rows[2])
              + BSW'(s3_rows[3]) + BSW'(s3_rows[4]);
    s5_blur  <= blur_val;
  end

endmodule

`default_nettype wire

FILE: rtl/iedi_cmd_fifo.sv
// ----------------------------------------------------------------------------
// iedi_cmd_fifo - command queue between front and back
// Register based FIFO with fill count; head visible without a read cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module iedi_cmd_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  iedi_pkg::cmd_t               push_cmd,
  input  logic                         pop,
  output iedi_pkg::cmd_t               head,
  output logic                         not_empty,
  output logic [iedi_pkg::QCNT_W-1:0]  count
);

  localparam int PTW = iedi_pkg::QPTR_W;
  localparam int CTW = iedi_pkg::QCNT_W;

  iedi_pkg::cmd_t mem [iedi_pkg::QUEUE_DEPTH];
  logic [PTW-1:0] wr_ptr, rd_ptr;
  logic           do_push, do_pop;

  assign not_empty = (count != '0);
  assign do_push   = push && (count != CTW'(iedi_pkg::QUEUE_DEPTH));
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= PTW'(32'(wr_ptr) + 1 == iedi_pkg::QUEUE_DEPTH ? 0 : 32'(wr_ptr) + 1);
      if (do_pop)  rd_ptr <= PTW'(32'(rd_ptr) + 1 == iedi_pkg::QUEUE_DEPTH ? 0 : 32'(rd_ptr) + 1);
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/iedi_back.sv
// ----------------------------------------------------------------------------
// iedi_back - Sobel gradient and integral accumulation
// Sequencer expands each command into one to sixteen results; column sums
// live in RAM with read-modify-write and one step of forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module iedi_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  iedi_pkg::cmd_t                   q_cmd,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [iedi_pkg::POS_OUT_W-1:0]   out_col,
  output logic [iedi_pkg::POS_OUT_W-1:0]   out_row,
  output logic [iedi_pkg::SUM_W-1:0]       integral_value,
  output logic                             last_of_run,
  output logic                             frame_done
);

  localparam int PW = iedi_pkg::PIX_W;
  localparam int CW = iedi_pkg::COL_W;
  localparam int RW = iedi_pkg::ROW_W;
  localparam int WW = iedi_pkg::WD_W;
  localparam int HW = iedi_pkg::HD_W;
  localparam int GW = iedi_pkg::GRAD_W;
  localparam int SW = iedi_pkg::SUM_W;
  localparam int OW = iedi_pkg::POS_OUT_W;

  function automatic logic signed [GW:0] sx(input logic [PW-1:0] v);
    return $signed({{(GW+1-PW){1'b0}}, v});
  endfunction

  // sequencer
  logic            s_valid;
  iedi_pkg::cmd_t  s_cmd;
  logic [1:0]      s_m, s_k, m_last, k_last;
  logic            s_last, load, adv;

  // job built from the sequencer
  logic [PW-1:0]       e [3][3];
  logic signed [GW:0]  gx, gy, ax, ay;
  logic [GW-1:0]       grad, job_g;
  logic [CW-1:0]       job_c;
  logic [RW-1:0]       job_r;
  logic                inner;

  // accumulate stage
  logic            a_valid, a_last, a_done;
  logic [CW-1:0]   a_c;
  logic [RW-1:0]   a_r;
  logic [1:0]      a_k;
  logic [GW-1:0]   a_g;
  logic            fwd_hit;
  logic [SW-1:0]   fwd_data, cs_rdata, cs_prev, cs_new, sum_v;
  logic [SW-1:0]   row_prefix [4];

  assign adv    = !out_valid || !out_stall;
  assign m_last = s_cmd.col_flush ? 2'd3 : 2'd0;
  assign k_last = s_cmd.row_flush ? 2'd3 : 2'd0;
  assign s_last = (s_m == m_last) && (s_k == k_last);
  assign load   = !s_valid || (adv && s_last);
  assign q_pop  = load && q_valid;

  assign job_c = s_cmd.pc - CW'(3) + CW'(s_m);
  assign job_r = s_cmd.pr - RW'(3) + RW'(s_k);

  // 3x3 view shifted right by m and down by k, zeros past the window
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((3'(s_k) + 3'(i)) < 3'd3 && (3'(s_m) + 3'(j)) < 3'd3) begin
          e[i][j] = s_cmd.gw[2'(s_k + 2'(i))][2'(s_m + 2'(j))];
        end else begin
          e[i][j] = '0;
        end
      end
    end
  end

  always_comb begin
    gx = sx(e[0][2]) - sx(e[0][0]) + ((sx(e[1][2]) - sx(e[1][0])) <<< 1)
       + sx(e[2][2]) - sx(e[2][0]);
    gy = sx(e[0][0]) + (sx(e[0][1]) <<< 1) + sx(e[0][2])
       - sx(e[2][0]) - (sx(e[2][1]) <<< 1) - sx(e[2][2]);
    ax = gx[GW] ? -gx : gx;
    ay = gy[GW] ? -gy : gy;
    grad = ax[GW-1:0] + ay[GW-1:0];
  end

  // gradient is zero on the outer ring
  assign inner = (job_c != '0) && (WW'(job_c) <= s_cmd.w - WW'(2))
              && (job_r != '0) && (HW'(job_r) <= s_cmd.h - HW'(2));
  assign job_g = inner ? grad : '0;

  iedi_ram #(.WIDTH(SW), .DEPTH(iedi_pkg::MAX_WIDTH)) u_col_sums (
    .clk   (clk),
    .we    (adv && a_valid),
    .waddr (a_c),
    .wdata (cs_new),
    .re    (adv),
    .raddr (job_c),
    .rdata (cs_rdata)
  );

  assign cs_prev = fwd_hit ? fwd_data : cs_rdata;
  assign cs_new  = ((a_r == '0) ? '0 : cs_prev) + SW'(a_g);
  assign sum_v   = ((a_c == '0) ? '0 : row_prefix[a_k]) + cs_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid    <= 1'b0;
      s_m        <= '0;
      s_k        <= '0;
      a_valid    <= 1'b0;
      out_valid  <= 1'b0;
      fwd_hit    <= 1'b0;
      row_prefix <= '{default: '0};
    end else begin
      if (load) begin
        s_valid <= q_valid;
        s_m     <= '0;
        s_k     <= '0;
      end else if (adv && s_valid) begin
        if (s_k == k_last) begin
          s_k <= '0;
          s_m <= s_m + 1'b1;
        end else begin
          s_k <= s_k + 1'b1;
        end
      end
      if (adv) begin
        a_valid   <= s_valid;
        out_valid <= a_valid;
        // same column written as it is read: RAM returns the old word
        fwd_hit   <= a_valid && s_valid && (a_c == job_c);
        if (a_valid) begin
          row_prefix[a_k] <= sum_v;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s_cmd <= q_cmd;
    end
    if (adv) begin
      a_c            <= job_c;
      a_r            <= job_r;
      a_k            <= s_k;
      a_g            <= job_g;
      a_last         <= s_last;
      a_done         <= s_last && s_cmd.col_flush && s_cmd.row_flush;
      fwd_data       <= cs_new;
      out_col        <= OW'(a_c);
      out_row        <= OW'(a_r);
      integral_value <= sum_v;
      last_of_run    <= a_last;
      frame_done     <= a_done;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/integral_edge_density_image.sv
// ----------------------------------------------------------------------------
// integral_edge_density_image - blurred Sobel edge density, integral image
// Streams grey pixels in raster order, blurs them with the 5x5 Gaussian
// (weights sum to 159), takes |gx|+|gy| and emits its 32-bit integral image.
// ----------------------------------------------------------------------------
// Throughput: one pixel and one result per cycle; the last pixel of a row
//   gives 4 results, each pixel of the last row 4, the final pixel 16, and
//   the back end emits one result per cycle while out_stall is low, so intake
//   pauses in those bursts.
// Reset: clears positions, pipelines, queue and row sums; stale line store
//   words read early in a frame are never used, so no clearing pass.
`default_nettype none

module integral_edge_density_image (
  input  logic                                clk,
  input  logic                                rst,
  // pixel input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [iedi_pkg::PIX_W-1:0]          pixel,
  // results
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [iedi_pkg::POS_OUT_W-1:0]      out_col,
  output logic [iedi_pkg::POS_OUT_W-1:0]      out_row,
  output logic [iedi_pkg::SUM_W-1:0]          integral_value,
  output logic                                last_of_run,
  output logic                                frame_done,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [iedi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [iedi_pkg::CFG_W-1:0]          cfg_data
);

  // Size registers; the front latches the clamped values on the first pixel
  // of each frame, so a write lands at the next frame.
  logic [iedi_pkg::CFG_W-1:0]  frame_width, frame_height;

  logic                        push, q_pop, q_not_empty;
  iedi_pkg::cmd_t              push_cmd, q_head;
  logic [iedi_pkg::QCNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= iedi_pkg::DIM_RESET;
      frame_height <= iedi_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        iedi_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        iedi_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Front: intake, pixel lines, blur, blur lines, 3x3 gradient window.
  // It only takes a pixel when the queue can hold everything in flight.
  iedi_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel        (pixel),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .q_count      (q_count),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  // Queue soaks up the edge flush bursts.
  iedi_cmd_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  // Back: Sobel per result, column sums and row prefix, output register.
  iedi_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_not_empty),
    .q_cmd          (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_col        (out_col),
    .out_row        (out_row),
    .integral_value (integral_value),
    .last_of_run    (last_of_run),
    .frame_done     (frame_done)
  );

endmodule

`default_nettype wire
